/* src/dta_pkg.sv */
`default_nettype none

package dta_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_VALUE_BITS = 64;
   localparam int DEF_MAX_DIGITS = 20;

   // BCD digits held by the converter, enough for any 64-bit magnitude
   localparam int BCD_DIGITS     = 20;
   localparam int DIGIT_BITS     = 4;
   localparam int BCD_BITS       = BCD_DIGITS * DIGIT_BITS;

   // Magnitude bits consumed per conversion cycle
   localparam int STEP_BITS      = 4;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH    = 2;

   // Character channel
   localparam int CHAR_BITS      = 8;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

   // Operation selector codes
   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

endpackage

`default_nettype wire

/* src/dta_front.sv */
`default_nettype none

module dta_front #(
   parameter int VALUE_BITS = dta_pkg::DEF_VALUE_BITS
) (
   input  wire logic [VALUE_BITS-1:0] value,
   input  wire logic                  operation,
   output logic                       negative,
   output logic [VALUE_BITS-1:0]      magnitude
);
   import dta_pkg::*;

   // Classify the value and take its magnitude; the most negative value
   // negates to its own pattern, which is its unsigned magnitude
   always_comb begin
      negative  = (operation == OP_SIGNED) && value[VALUE_BITS-1];
      magnitude = negative ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
   end

endmodule

`default_nettype wire

/* src/dta_queue.sv */
`default_nettype none

module dta_queue #(
   parameter int WIDTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);
   import dta_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push_fire, pop_fire;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/dta_back.sv */
`default_nettype none

module dta_back #(
   parameter int VALUE_BITS = dta_pkg::DEF_VALUE_BITS,
   parameter int MAX_DIGITS = dta_pkg::DEF_MAX_DIGITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   output logic                               job_ready,
   input  wire logic                          job_negative,
   input  wire logic [VALUE_BITS-1:0]         job_magnitude,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [dta_pkg::CHAR_BITS-1:0]      rsp_tdata,
   output logic                               rsp_tlast
);
   import dta_pkg::*;

   localparam int STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS  = STEPS * STEP_BITS;
   localparam int STEP_CNT  = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_BITS  = $clog2(MAX_DIGITS);
   localparam logic [STEP_CNT-1:0] LAST_STEP = STEP_CNT'(STEPS - 1);
   localparam logic [IDX_BITS-1:0] TOP_IDX   = IDX_BITS'(MAX_DIGITS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_COUNT = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [PAD_BITS-1:0]  shift_ff, shift_in;
   logic [BCD_BITS-1:0]  bcd_ff, bcd_in;
   logic                 neg_ff, neg_in;
   logic [STEP_CNT-1:0]  step_ff, step_in;
   logic [IDX_BITS-1:0]  idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0] rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 out_free;
   logic [IDX_BITS-1:0]  top_idx;
   logic [DIGIT_BITS-1:0] cur_digit;

   // One double-dabble pass over STEP_BITS magnitude bits, MSB first
   function automatic logic [BCD_BITS-1:0] dabble(
      input logic [BCD_BITS-1:0]  bcd,
      input logic [STEP_BITS-1:0] bits
   );
      logic [BCD_BITS-1:0] b;
      b = bcd;
      for (int j = STEP_BITS - 1; j >= 0; j--) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (b[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
               b[d*DIGIT_BITS +: DIGIT_BITS] = b[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end
         end
         b = {b[BCD_BITS-2:0], bits[j]};
      end
      return b;
   endfunction

   // Index of the leading digit, clipped to the kept digits
   always_comb begin
      top_idx = '0;
      for (int d = 1; d < BCD_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
            top_idx = (d >= MAX_DIGITS - 1) ? TOP_IDX : IDX_BITS'(d);
         end
      end
   end

   assign cur_digit  = bcd_ff[idx_ff*DIGIT_BITS +: DIGIT_BITS];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign job_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Sequence: load, convert, size, emit sign and digits
   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               shift_in = PAD_BITS'(job_magnitude);
               bcd_in   = '0;
               neg_in   = job_negative;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in   = dabble(bcd_ff, shift_ff[PAD_BITS-1 -: STEP_BITS]);
            shift_in = shift_ff << STEP_BITS;
            step_in  = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            idx_in   = top_idx;
            state_in = neg_ff ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + CHAR_BITS'(cur_digit);
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

/* src/int_to_decimal_ascii.sv */
// int_to_decimal_ascii: prints an integer as decimal ASCII text.
//
// Input stream (req_): one transfer per value. req_tdata carries the value
// in its low VALUE_BITS bits; req_tuser selects unsigned (0) or two's
// complement signed (1).
// Output stream (rsp_): one transfer per character, most significant first:
// a '-' for a negative signed value, then the digits. rsp_tlast marks the
// final character. Zero prints as "0"; only the MAX_DIGITS low digits kept.
//
// Timing: a value sits in a two-entry queue until the converter is free.
// The converter loads the value, runs double dabble over the magnitude at
// 4 magnitude bits per cycle and sizes the result, then emits one character
// per cycle while rsp_tready allows. It takes the next value from the queue
// only after emitting the final character of the one before.
// Reset clears the queue, the sequencer and the output valid.
// A stall on rsp_tready holds the current character; the converter waits,
// and the queue keeps accepting values until both entries are full.
`default_nettype none

module int_to_decimal_ascii #(
   parameter int VALUE_BITS = dta_pkg::DEF_VALUE_BITS,
   parameter int MAX_DIGITS = dta_pkg::DEF_MAX_DIGITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // value, zero padded to whole bytes
   input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] req_tdata,
   // operation
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // character
   output logic [dta_pkg::CHAR_BITS-1:0]              rsp_tdata,
   output logic                                       rsp_tlast
);
   import dta_pkg::*;

   localparam int JOB_BITS = VALUE_BITS + 1;

   logic                  front_negative;
   logic [VALUE_BITS-1:0] front_magnitude;
   logic                  job_valid, job_ready;
   logic [JOB_BITS-1:0]   job_data;

   // Classify the incoming value
   dta_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .value     (req_tdata[VALUE_BITS-1:0]),
      .operation (req_tuser),
      .negative  (front_negative),
      .magnitude (front_magnitude)
   );

   // Decouple intake from conversion
   dta_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  ({front_negative, front_magnitude}),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (job_data)
   );

   // Convert and emit characters
   dta_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job_ready     (job_ready),
      .job_negative  (job_data[JOB_BITS-1]),
      .job_magnitude (job_data[VALUE_BITS-1:0]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

`default_nettype wire

/* src/dta_checker.sv */
`default_nettype none

module dta_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [dta_pkg::CHAR_BITS-1:0] rsp_tdata,
   input wire logic                          rsp_tlast
);
   import dta_pkg::*;

   logic after_minus_ff;

   // Track a sign just transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         after_minus_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         after_minus_ff <= (rsp_tdata == ASCII_MINUS);
      end
   end

   // Output drops after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Stalled character holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled character changed");

   // Sign is never the last character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == ASCII_MINUS) |-> !rsp_tlast)
      else $error("sign marked last");

   // A digit follows the sign
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && after_minus_ff |->
         (rsp_tdata >= ASCII_ZERO) && (rsp_tdata <= ASCII_ZERO + 8'd9))
      else $error("sign not followed by a digit");

endmodule

bind int_to_decimal_ascii dta_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
   import dta_pkg::*;

   localparam int VALUE_BITS  = DEF_VALUE_BITS;
   localparam int MAX_DIGITS  = DEF_MAX_DIGITS;
   localparam int DATA_BITS   = ((VALUE_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 600000;
   // Worst case from transfer to final character plus margin
   localparam int SETTLE_CYCLES = 60;

   // One printed character and its end-of-text mark
   typedef struct packed {
      logic [CHAR_BITS-1:0] code;
      logic                 last;
   } text_char_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;
   logic                 req_tuser  = OP_UNSIGNED;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [CHAR_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;

   text_char_type pending_text[$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            stall_left  = 0;
   bit            idling_on   = 1'b1;

   int_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),   // value
      .req_tuser (req_tuser),   // operation
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),   // character
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Work out the decimal text of one value and queue its characters
   function automatic void predict_text(input logic [63:0] raw, input logic op);
      logic [63:0]   mask;
      logic [63:0]   v;
      logic [63:0]   mag;
      logic [3:0]    digits[MAX_DIGITS];
      bit            neg;
      int            count;
      text_char_type ch;
      mask  = {64{1'b1}} >> (64 - VALUE_BITS);
      v     = raw & mask;
      neg   = (op == OP_SIGNED) && v[VALUE_BITS-1];
      mag   = neg ? ((~v + 64'd1) & mask) : v;
      count = 0;
      // Peel off digits, least significant first, keeping at most MAX_DIGITS
      do begin
         digits[count] = 4'(mag % 64'd10);
         mag           = mag / 64'd10;
         count++;
      end while (mag != 0 && count < MAX_DIGITS);
      if (neg) begin
         ch.code = ASCII_MINUS;
         ch.last = 1'b0;
         pending_text.push_back(ch);
      end
      for (int k = count - 1; k >= 0; k--) begin
         ch.code = ASCII_ZERO + CHAR_BITS'(digits[k]);
         ch.last = (k == 0);
         pending_text.push_back(ch);
      end
   endfunction

   // Offer one value, with an optional gap first, and hold until the transfer
   task automatic send_value(input logic [63:0] value, input logic op);
      if (idling_on && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_BITS'(value);
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predict_text(value, op);
   endtask

   // Drop valid and wait for every pending character to come out
   task automatic drain_text();
      req_tvalid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
   endtask

   // A power of ten, nudged by one either way now and then
   function automatic logic [63:0] near_power_of_ten();
      logic [63:0] p;
      p = 64'd1;
      repeat ($urandom_range(0, 19)) p = p * 64'd10;
      case ($urandom_range(0, 2))
         0: p = p - 64'd1;
         1: p = p + 64'd1;
         default: ;
      endcase
      return p;
   endfunction

   // Random value whose length in bits varies, so digit counts vary too
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      int          len;
      len = $urandom_range(1, 64);
      v   = {$urandom, $urandom};
      if (len < 64) v = v & ((64'd1 << len) - 64'd1);
      return v;
   endfunction

   // Well-formed mix: short and long values, negatives, decade boundaries
   task automatic send_random_item();
      logic [63:0] v;
      logic        op;
      op = $urandom_range(0, 1) ? OP_SIGNED : OP_UNSIGNED;
      case ($urandom_range(0, 7))
         0: v = near_power_of_ten();
         1, 2: begin
            v  = ~random_value() + 64'd1;
            op = OP_SIGNED;
         end
         3: v = {$urandom, $urandom};
         default: v = random_value();
      endcase
      send_value(v, op);
   endtask

   task automatic test_directed();
      send_value(64'd0, OP_UNSIGNED);
      send_value(64'd0, OP_SIGNED);
      send_value(64'd1, OP_UNSIGNED);
      send_value(64'd9, OP_SIGNED);
      send_value(64'd10, OP_UNSIGNED);
      send_value(64'd99, OP_SIGNED);
      send_value(64'd100, OP_SIGNED);
      send_value(64'hFFFF_FFFF_FFFF_FFFF, OP_UNSIGNED);
      send_value(64'hFFFF_FFFF_FFFF_FFFF, OP_SIGNED);
      // most negative signed value and its unsigned twin
      send_value(64'h8000_0000_0000_0000, OP_SIGNED);
      send_value(64'h8000_0000_0000_0000, OP_UNSIGNED);
      send_value(64'h7FFF_FFFF_FFFF_FFFF, OP_SIGNED);
      send_value(64'h7FFF_FFFF_FFFF_FFFF, OP_UNSIGNED);
      send_value(64'd10000000000000000000, OP_UNSIGNED);
      send_value(64'd9999999999999999999, OP_UNSIGNED);
      send_value(64'd12345678901234567890, OP_UNSIGNED);
      send_value(64'd1000000000000000000, OP_SIGNED);
      send_value(-64'sd10, OP_SIGNED);
      send_value(-64'sd9, OP_SIGNED);
      send_value(-64'sd999999, OP_SIGNED);
      send_value(64'hAAAA_AAAA_AAAA_AAAA, OP_UNSIGNED);
      send_value(64'h5555_5555_5555_5555, OP_SIGNED);
      send_value(64'hAAAA_AAAA_AAAA_AAAA, OP_SIGNED);
   endtask

   task automatic test_random_text(input int count);
      repeat (count) send_random_item();
   endtask

   task automatic test_pause_until_drained();
      repeat (6) send_random_item();
      drain_text();
      repeat (6) send_random_item();
   endtask

   task automatic test_back_to_back(input int count);
      drain_text();
      idling_on = 1'b0;
      repeat (count) send_random_item();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_text(150);
      test_pause_until_drained();
      test_random_text(120);
      test_back_to_back(50);
      req_tvalid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Receiver: stall in random bursts while idling is on
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 8);
      end
      rsp_tready <= (stall_left == 0);
   end

   // Compare each character transfer against the oldest pending one
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_text.size() == 0) begin
            $error("unexpected character %0d (last %0b) with no text pending",
                   rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_text.pop_front();
            if (rsp_tdata !== want.code) begin
               $error("character mismatch: expected %0d, actual %0d", want.code, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last mismatch: expected %0b, actual %0b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
